// ----- sv/rqs_pkg.sv -----
// Shared types for the resumable quicksort engine: request codes, command and status words.
package rqs_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 256;
    localparam int unsigned COUNT_W          = 9;
    localparam int unsigned VALUE_W          = 32;
    localparam int unsigned SWAP_W           = 16;
    localparam int unsigned INDEX_W          = 8;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        RA_IDX,
        RA_SCAN,
        RA_EA,
        RA_EB,
        RA_L,
        RA_R
    } rd_sel_t;

    typedef enum logic [1:0] {
        WS_REQ,
        WS_EA,
        WS_EB
    } wr_sel_t;

    typedef struct packed {
        logic    latch_req;
        rd_sel_t rd_sel;
        logic    mem_we;
        wr_sel_t wr_sel;
        logic    clear_prog;
        logic    cap_read;
        logic    sc_clear;
        logic    sc_inc;
        logic    prev_load;
        logic    fin_set;
        logic    fin_val;
        logic    stk_clear;
        logic    stk_push_init;
        logic    stk_push_right;
        logic    stk_push_left;
        logic    stk_pop;
        logic    load_range;
        logic    pick_setup;
        logic    scan_setup;
        logic    place_setup;
        logic    cap_da;
        logic    load_pivot;
        logic    l_inc;
        logic    r_dec;
        logic    swap_inc;
        logic    out_load;
    } rqs_cmd_t;

    typedef struct packed {
        req_t req_type;
        logic count_lt2;
        logic sc_zero;
        logic sc_last;
        logic desc;
        logic level_zero;
        logic l_lt_r;
        logic l_ne_r;
        logic le_piv;
        logic ge_piv;
        logic swaps_hit;
        logic right_ok;
        logic left_ok;
    } rqs_status_t;

endpackage

// ----- sv/rqs_if.sv -----
// Word channel interfaces: request and response.
interface rqs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  elem_index;
    logic [31:0] elem_value;
    logic [15:0] swap_budget;

    modport source (output valid, output req_type, output elem_index, output elem_value,
                    output swap_budget, input ready);
    modport sink   (input valid, input req_type, input elem_index, input elem_value,
                    input swap_budget, output ready);
endinterface

interface rqs_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [15:0] swaps_done;
    logic        sort_finished;

    modport source (output valid, output read_value, output swaps_done, output sort_finished,
                    input ready);
    modport sink   (input valid, input read_value, input swaps_done, input sort_finished,
                    output ready);
endinterface

// ----- sv/rqs_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module rqs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/rqs_datapath.sv -----
// Datapath: element and range stores, cursors, pivot, counters and result registers.
module rqs_datapath #(
    parameter int unsigned MAX_ELEMENTS = rqs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_data,
    input  logic [1:0]          in_req_type,
    input  logic [7:0]          in_elem_index,
    input  logic [31:0]         in_elem_value,
    input  logic [15:0]         in_swap_budget,
    input  rqs_pkg::rqs_cmd_t   cmd,
    output rqs_pkg::rqs_status_t status,
    output logic [31:0]         out_read_value,
    output logic [15:0]         out_swaps_done,
    output logic                out_sort_finished
);
    import rqs_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned LW = $clog2(MAX_ELEMENTS + 1);

    // control state
    logic [COUNT_W-1:0] count_reg;
    logic [LW-1:0]      level_reg;
    logic [AW-1:0]      l_reg;
    logic [AW-1:0]      r_reg;
    logic signed [VALUE_W-1:0] pivot_reg;

    // payload
    req_t               type_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [SWAP_W-1:0]  budget_reg;
    logic [AW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      ea_reg;
    logic [AW-1:0]      eb_reg;
    logic [VALUE_W-1:0] da_reg;
    logic signed [VALUE_W-1:0] prev_reg;
    logic [COUNT_W-1:0] sc_reg;
    logic [SWAP_W-1:0]  swaps_reg;
    logic [VALUE_W-1:0] rv_reg;
    logic               fin_reg;
    logic [VALUE_W-1:0] out_rv_reg;
    logic [SWAP_W-1:0]  out_sw_reg;
    logic               out_fin_reg;

    logic               idx_ok;
    logic [AW:0]        mid_sum;
    logic [AW-1:0]      mid;
    logic [SWAP_W-1:0]  eff_budget;
    logic [COUNT_W-1:0] cfg_sat;

    logic               e_we;
    logic [AW-1:0]      e_waddr;
    logic [AW-1:0]      e_raddr;
    logic [VALUE_W-1:0] e_wdata;
    logic [VALUE_W-1:0] e_rdata;
    logic signed [VALUE_W-1:0] e_rs;

    logic               s_we;
    logic [AW-1:0]      s_waddr;
    logic [2*AW-1:0]    s_wdata;
    logic [2*AW-1:0]    s_rdata;
    logic               push_ok;

    assign idx_ok     = 32'(idx_reg) < MAX_ELEMENTS;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[AW:1];
    assign eff_budget = (budget_reg == '0) ? SWAP_W'(1) : budget_reg;
    assign cfg_sat    = (32'(cfg_data) > MAX_ELEMENTS) ? COUNT_W'(MAX_ELEMENTS) : cfg_data;
    assign e_rs       = e_rdata;
    assign push_ok    = 32'(level_reg) < MAX_ELEMENTS;

    // element store ports
    always_comb
    begin
        case (cmd.rd_sel)
            RA_IDX:  e_raddr = AW'(idx_reg);
            RA_SCAN: e_raddr = AW'(sc_reg);
            RA_EA:   e_raddr = ea_reg;
            RA_EB:   e_raddr = eb_reg;
            RA_L:    e_raddr = l_reg;
            RA_R:    e_raddr = r_reg;
            default: e_raddr = AW'(idx_reg);
        endcase
        case (cmd.wr_sel)
            WS_REQ:
            begin
                e_waddr = AW'(idx_reg);
                e_wdata = value_reg;
                e_we    = cmd.mem_we && idx_ok;
            end
            WS_EA:
            begin
                e_waddr = ea_reg;
                e_wdata = e_rdata;
                e_we    = cmd.mem_we;
            end
            WS_EB:
            begin
                e_waddr = eb_reg;
                e_wdata = da_reg;
                e_we    = cmd.mem_we;
            end
            default:
            begin
                e_waddr = ea_reg;
                e_wdata = e_rdata;
                e_we    = 1'b0;
            end
        endcase
    end

    // range stack ports
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = AW'(level_reg);
        s_wdata = {l_reg + AW'(1), hi_reg};
        if (cmd.stk_push_init)
        begin
            s_we    = 1'b1;
            s_waddr = '0;
            s_wdata = {AW'(0), AW'(count_reg - COUNT_W'(1))};
        end
        else if (cmd.stk_push_right)
        begin
            s_we    = push_ok;
        end
        else if (cmd.stk_push_left)
        begin
            s_we    = push_ok;
            s_wdata = {lo_reg, l_reg - AW'(1)};
        end
    end

    rqs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    rqs_ram #(.WIDTH(2 * AW), .DEPTH(MAX_ELEMENTS)) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (AW'(level_reg - LW'(1))),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= '0;
            l_reg     <= '0;
            r_reg     <= '0;
            pivot_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_sat;
            level_reg <= '0;
            l_reg     <= '0;
            r_reg     <= '0;
            pivot_reg <= '0;
        end
        else if (cmd.clear_prog)
        begin
            level_reg <= '0;
            l_reg     <= '0;
            r_reg     <= '0;
            pivot_reg <= '0;
        end
        else
        begin
            if (cmd.stk_clear)
            begin
                level_reg <= '0;
            end
            else if (cmd.stk_push_init)
            begin
                level_reg <= LW'(1);
            end
            else if ((cmd.stk_push_right || cmd.stk_push_left) && push_ok)
            begin
                level_reg <= level_reg + LW'(1);
            end
            else if (cmd.stk_pop)
            begin
                level_reg <= level_reg - LW'(1);
            end
            if (cmd.pick_setup)
            begin
                l_reg <= lo_reg;
                r_reg <= hi_reg;
            end
            if (cmd.l_inc)
            begin
                l_reg <= l_reg + AW'(1);
            end
            if (cmd.r_dec)
            begin
                r_reg <= r_reg - AW'(1);
            end
            if (cmd.load_pivot)
            begin
                pivot_reg <= e_rs;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            type_reg   <= req_t'(in_req_type);
            idx_reg    <= in_elem_index;
            value_reg  <= in_elem_value;
            budget_reg <= in_swap_budget;
            rv_reg     <= '0;
            swaps_reg  <= '0;
        end
        if (cmd.cap_read)
        begin
            rv_reg <= idx_ok ? e_rdata : '0;
        end
        if (cmd.swap_inc)
        begin
            swaps_reg <= swaps_reg + SWAP_W'(1);
        end
        if (cmd.sc_clear)
        begin
            sc_reg <= '0;
        end
        else if (cmd.sc_inc)
        begin
            sc_reg <= sc_reg + COUNT_W'(1);
        end
        if (cmd.prev_load)
        begin
            prev_reg <= e_rs;
        end
        if (cmd.fin_set)
        begin
            fin_reg <= cmd.fin_val;
        end
        if (cmd.load_range)
        begin
            lo_reg <= s_rdata[2*AW-1:AW];
            hi_reg <= s_rdata[AW-1:0];
        end
        if (cmd.pick_setup)
        begin
            ea_reg <= mid;
            eb_reg <= hi_reg;
        end
        else if (cmd.scan_setup)
        begin
            ea_reg <= l_reg;
            eb_reg <= r_reg;
        end
        else if (cmd.place_setup)
        begin
            ea_reg <= l_reg;
            eb_reg <= hi_reg;
        end
        if (cmd.cap_da)
        begin
            da_reg <= e_rdata;
        end
        if (cmd.out_load)
        begin
            out_rv_reg  <= rv_reg;
            out_sw_reg  <= swaps_reg;
            out_fin_reg <= fin_reg;
        end
    end

    assign status.req_type   = type_reg;
    assign status.count_lt2  = count_reg < COUNT_W'(2);
    assign status.sc_zero    = sc_reg == '0;
    assign status.sc_last    = (sc_reg + COUNT_W'(1)) == count_reg;
    assign status.desc       = prev_reg > e_rs;
    assign status.level_zero = level_reg == '0;
    assign status.l_lt_r     = l_reg < r_reg;
    assign status.l_ne_r     = l_reg != r_reg;
    assign status.le_piv     = e_rs <= pivot_reg;
    assign status.ge_piv     = e_rs >= pivot_reg;
    assign status.swaps_hit  = swaps_reg >= eff_budget;
    assign status.right_ok   = ({1'b0, l_reg} + (AW + 1)'(1)) < {1'b0, hi_reg};
    assign status.left_ok    = ({1'b0, lo_reg} + (AW + 1)'(1)) < {1'b0, l_reg};

    assign out_read_value    = out_rv_reg;
    assign out_swaps_done    = out_sw_reg;
    assign out_sort_finished = out_fin_reg;
endmodule

// ----- sv/rqs_controller.sv -----
// Controller: sequences requests, sortedness scans and the partition steps.
module rqs_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rqs_pkg::rqs_status_t status,
    output rqs_pkg::rqs_cmd_t    cmd
);
    import rqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_RDD, S_CHK, S_CHA, S_CHD, S_CDONE, S_OUT,
        S_LOOP, S_TOP_RD, S_TOP_WT, S_DISP,
        S_LA, S_LD, S_RA, S_RD, S_SW,
        S_XRA, S_XRB, S_XWA, S_XWB,
        S_PL_POP, S_PL_P1, S_PL_P2, S_PL_FIN, S_BCHK
    } state_t;

    typedef enum logic [1:0] {PH_IDLE, PH_PICK, PH_SCAN, PH_PLACE} phase_t;
    typedef enum logic [1:0] {CTX_PICK, CTX_SCAN, CTX_PLACE} ctx_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    ctx_t   ctx_reg, ctx_next;
    logic   pre_reg, pre_next;
    logic   sorted_reg, sorted_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        ctx_next    = ctx_reg;
        pre_next    = pre_reg;
        sorted_next = sorted_reg;
        ov_next     = ov_reg && !out_ready;
        cmd         = '0;
        cmd.rd_sel  = RA_IDX;
        cmd.wr_sel  = WS_REQ;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC:
            begin
                pre_next   = 1'b0;
                state_next = S_CHK;
                case (status.req_type)
                    REQ_WRITE:
                    begin
                        cmd.mem_we     = 1'b1;
                        cmd.wr_sel     = WS_REQ;
                        cmd.clear_prog = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                    REQ_READ:
                    begin
                        cmd.rd_sel = RA_IDX;
                        state_next = S_RDD;
                    end
                    REQ_RUN:  pre_next = 1'b1;
                    default:  ;
                endcase
            end
            S_RDD:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_CHK;
            end
            // sortedness scan: S_CHA reads an element, S_CHD compares it with the previous one
            S_CHK:
            begin
                cmd.sc_clear = 1'b1;
                if (status.count_lt2)
                begin
                    sorted_next = 1'b1;
                    state_next  = S_CDONE;
                end
                else
                begin
                    state_next = S_CHA;
                end
            end
            S_CHA:
            begin
                cmd.rd_sel = RA_SCAN;
                state_next = S_CHD;
            end
            S_CHD:
            begin
                if (!status.sc_zero && status.desc)
                begin
                    sorted_next = 1'b0;
                    state_next  = S_CDONE;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.sc_inc    = 1'b1;
                    if (status.sc_last)
                    begin
                        sorted_next = 1'b1;
                        state_next  = S_CDONE;
                    end
                    else
                    begin
                        state_next = S_CHA;
                    end
                end
            end
            S_CDONE:
            begin
                pre_next = 1'b0;
                if (pre_reg && !sorted_reg)
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    cmd.fin_set = 1'b1;
                    cmd.fin_val = sorted_reg;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // burst loop head
            S_LOOP:
            begin
                state_next = S_TOP_RD;
                if (phase_reg == PH_IDLE || status.level_zero)
                begin
                    if (status.count_lt2)
                    begin
                        cmd.stk_clear = 1'b1;
                        state_next    = S_CHK;
                    end
                    else
                    begin
                        cmd.stk_push_init = 1'b1;
                        phase_next        = PH_PICK;
                    end
                end
            end
            S_TOP_RD:
            begin
                state_next = S_TOP_WT;
            end
            S_TOP_WT:
            begin
                cmd.load_range = 1'b1;
                state_next     = S_DISP;
            end
            S_DISP:
            begin
                case (phase_reg)
                    PH_PICK:
                    begin
                        cmd.pick_setup = 1'b1;
                        phase_next     = PH_SCAN;
                        ctx_next       = CTX_PICK;
                        state_next     = S_XRA;
                    end
                    PH_SCAN:
                    begin
                        if (status.l_lt_r)
                        begin
                            state_next = S_LA;
                        end
                        else
                        begin
                            phase_next = PH_PLACE;
                            state_next = S_LOOP;
                        end
                    end
                    default:
                    begin
                        cmd.place_setup = 1'b1;
                        ctx_next        = CTX_PLACE;
                        state_next      = S_XRA;
                    end
                endcase
            end
            // left cursor climbs past elements not above the pivot
            S_LA:
            begin
                cmd.rd_sel = RA_L;
                state_next = status.l_lt_r ? S_LD : S_RA;
            end
            S_LD:
            begin
                if (status.le_piv)
                begin
                    cmd.l_inc  = 1'b1;
                    state_next = S_LA;
                end
                else
                begin
                    state_next = S_RA;
                end
            end
            // right cursor falls past elements not below the pivot
            S_RA:
            begin
                cmd.rd_sel = RA_R;
                state_next = status.l_lt_r ? S_RD : S_SW;
            end
            S_RD:
            begin
                if (status.ge_piv)
                begin
                    cmd.r_dec  = 1'b1;
                    state_next = S_RA;
                end
                else
                begin
                    state_next = S_SW;
                end
            end
            S_SW:
            begin
                if (status.l_ne_r)
                begin
                    cmd.scan_setup = 1'b1;
                    ctx_next       = CTX_SCAN;
                    state_next     = S_XRA;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            // exchange of two elements
            S_XRA:
            begin
                cmd.rd_sel = RA_EA;
                state_next = S_XRB;
            end
            S_XRB:
            begin
                cmd.rd_sel     = RA_EB;
                cmd.cap_da     = 1'b1;
                cmd.load_pivot = (ctx_reg == CTX_PICK);
                state_next     = S_XWA;
            end
            S_XWA:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = WS_EA;
                state_next = S_XWB;
            end
            S_XWB:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = WS_EB;
                if (ctx_reg == CTX_PLACE)
                begin
                    state_next = S_PL_POP;
                end
                else
                begin
                    cmd.swap_inc = 1'b1;
                    state_next   = S_BCHK;
                end
            end
            S_PL_POP:
            begin
                cmd.stk_pop = 1'b1;
                state_next  = S_PL_P1;
            end
            S_PL_P1:
            begin
                cmd.stk_push_right = status.right_ok;
                state_next         = S_PL_P2;
            end
            S_PL_P2:
            begin
                cmd.stk_push_left = status.left_ok;
                state_next        = S_PL_FIN;
            end
            S_PL_FIN:
            begin
                cmd.swap_inc = 1'b1;
                phase_next   = status.level_zero ? PH_IDLE : PH_PICK;
                state_next   = S_BCHK;
            end
            S_BCHK:
            begin
                if (phase_reg == PH_IDLE || status.swaps_hit)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_we)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_IDLE;
            ctx_reg    <= CTX_PICK;
            pre_reg    <= 1'b0;
            sorted_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ctx_reg    <= ctx_next;
            pre_reg    <= pre_next;
            sorted_reg <= sorted_next;
            ov_reg     <= ov_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ov_reg;
endmodule

// ----- sv/resumable_quicksort_engine.sv -----
// Top level of the resumable quicksort engine: controller, datapath and channel hookup.
//
// Usage: one request word on req gives exactly one response word on rsp.
//   req_type 0 writes elem_value at elem_index and drops all sort progress.
//   req_type 1 continues the in-place quicksort until swap_budget swaps are
//   done (0 counts as 1) or the array is sorted; req_type 2 reads an element.
// cfg_we/cfg_data set element_count (saturated to MAX_ELEMENTS); this also
//   drops sort progress. Write it only while the engine is idle.
// Steps: every request ends with a sortedness scan that reads and compares each
//   element in turn, stopping at a descent; a read first captures its element.
//   A run on an unsorted array scans before and after its swaps; each swap does
//   two reads, two writes and the budget check, each cursor compare a read and a
//   test, each pass of the loop head a stack read, and returning the pivot a pop.
// Throughput: one request at a time; req.ready is high only between requests.
// A finished response sits in the output register; while rsp stalls, the next
//   request may be taken and worked on, and waits only to hand its result over.
// Reset: element_count 0, no sort progress; element contents are undefined
//   until written. No clearing pass is needed.
module resumable_quicksort_engine #(
    parameter int unsigned MAX_ELEMENTS = rqs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data,
    rqs_req_if.sink    req,
    rqs_rsp_if.source  rsp
);
    import rqs_pkg::*;

    rqs_cmd_t    cmd;
    rqs_status_t status;

    rqs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rqs_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .in_req_type       (req.req_type),
        .in_elem_index     (req.elem_index),
        .in_elem_value     (req.elem_value),
        .in_swap_budget    (req.swap_budget),
        .cmd               (cmd),
        .status            (status),
        .out_read_value    (rsp.read_value),
        .out_swaps_done    (rsp.swaps_done),
        .out_sort_finished (rsp.sort_finished)
    );
endmodule
